// File: rtl/tgs_pkg.sv
// shared types, constants and register codes for the trilinear grid sampler
package tgs_pkg;

	// fixed field widths
	localparam int ADDR_W = 15;
	localparam int VOL_DEPTH = 1 << ADDR_W;
	localparam int POS_W = 24;
	localparam int INV_W = 24;
	localparam int SCALE_W = POS_W + INV_W;
	localparam int DIM_REG_W = 6;
	localparam int DIM_CMP_W = 9;
	localparam int IDX_INT_W = 16;
	localparam int LOAD_W = 32;
	localparam int OUT_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CORNERS = 8;

	// parameter defaults
	localparam int MAX_DIM_DEF = 32;
	localparam int TIME_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// reset values of the registers
	localparam logic [DIM_REG_W-1:0] DIM_RST = DIM_REG_W'(32);
	localparam logic [INV_W-1:0] INV_RST = INV_W'(1677722);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM_Z = 3'd0,
		CFG_DIM_X = 3'd1,
		CFG_DIM_Y = 3'd2,
		CFG_INV_DX = 3'd3,
		CFG_INV_DY = 3'd4,
		CFG_INV_DZ = 3'd5
	} cfg_idx_t;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

endpackage

// File: rtl/tgs_ram.sv
// generic single-port ram with registered read
module tgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read while en is high, one access per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/trilinear_grid_sampler.sv
// top level of the trilinear grid sampler: eleven-stage pipeline over a replicated volume
//
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------------
// request   | in_valid / in_ready        | req_type, load_addr, load_time, pos_x/y/z
// result    | out_valid / out_ready      | time_out, out_of_range
// config    | cfg_we                     | cfg_index, cfg_data
//
// one request per cycle while in_ready is high; a query passes stages 1 to 11 in order and its
// result is shown on out_valid from the stage 11 register
// loads write all eight copies of the volume on leaving stage 4 and give no result
// each corner is read from its own copy of the volume, one read port per copy
// every stage holds its own valid bit; a stage moves when it is empty or the next one moves
// reset clears valid bits and sets configuration registers to their reset values; the volume holds nothing until loaded
module trilinear_grid_sampler #(
	parameter int MAX_DIM = tgs_pkg::MAX_DIM_DEF,
	parameter int TIME_BITS = tgs_pkg::TIME_BITS_DEF,
	parameter int FRAC_BITS = tgs_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tgs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tgs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [tgs_pkg::ADDR_W-1:0]      load_addr,
	input  logic [tgs_pkg::LOAD_W-1:0]      load_time,
	input  logic [tgs_pkg::POS_W-1:0]       pos_x,
	input  logic [tgs_pkg::POS_W-1:0]       pos_y,
	input  logic [tgs_pkg::POS_W-1:0]       pos_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tgs_pkg::OUT_W-1:0]       time_out,
	output logic                            out_of_range
);

	import tgs_pkg::*;

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PROD_W = TIME_BITS + FRAC_BITS + 1;
	localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	// configuration registers
	logic [DIM_REG_W-1:0] dim_z_q, dim_x_q, dim_y_q;
	logic [INV_W-1:0] inv_dx_q, inv_dy_q, inv_dz_q;
	logic [ADDR_W-1:0] nxnz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_z_q <= DIM_RST;
			dim_x_q <= DIM_RST;
			dim_y_q <= DIM_RST;
			inv_dx_q <= INV_RST;
			inv_dy_q <= INV_RST;
			inv_dz_q <= INV_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DIM_Z: dim_z_q <= cfg_data[DIM_REG_W-1:0];
				CFG_DIM_X: dim_x_q <= cfg_data[DIM_REG_W-1:0];
				CFG_DIM_Y: dim_y_q <= cfg_data[DIM_REG_W-1:0];
				CFG_INV_DX: inv_dx_q <= cfg_data;
				CFG_INV_DY: inv_dy_q <= cfg_data;
				CFG_INV_DZ: inv_dz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last usable index per axis, zero counts as one and large counts as the maximum
	function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_REG_W-1:0] d);
		logic [IDX_W-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (DIM_CMP_W'(d) > DIM_CMP_W'(MAX_DIM)) begin
			r = IDX_W'(MAX_DIM - 1);
		end else begin
			r = IDX_W'(d - DIM_REG_W'(1));
		end
		return r;
	endfunction

	logic [IDX_W-1:0] lz, lx, ly;
	logic [ADDR_W-1:0] nz, nx;
	assign lz = last_idx(dim_z_q);
	assign lx = last_idx(dim_x_q);
	assign ly = last_idx(dim_y_q);
	assign nz = ADDR_W'(lz) + ADDR_W'(1);
	assign nx = ADDR_W'(lx) + ADDR_W'(1);

	// plane stride, follows the dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxnz_q <= '0;
		end else begin
			nxnz_q <= nx * nz;
		end
	end

	// stage moves
	logic [11:1] adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	assign adv[11] = !v_s11 || out_ready;
	assign adv[10] = !v_s10 || adv[11];
	assign adv[9] = !v_s9 || adv[10];
	assign adv[8] = !v_s8 || adv[9];
	assign adv[7] = !v_s7 || adv[8];
	assign adv[6] = !v_s6 || adv[7];
	assign adv[5] = !v_s5 || adv[6];
	assign adv[4] = !v_s4 || adv[5];
	assign adv[3] = !v_s3 || adv[4];
	assign adv[2] = !v_s2 || adv[3];
	assign adv[1] = !v_s1 || adv[2];
	assign in_ready = adv[1];

	// pipeline payload
	logic q_s1, q_s2, q_s3, q_s4;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3, addr_s4;
	logic [TIME_BITS-1:0] lt_s1, lt_s2, lt_s3, lt_s4;
	logic [SCALE_W-1:0] px_s1, py_s1, pz_s1;
	logic [IDX_W-1:0] x0_s2, x1_s2, y0_s2, y1_s2, z0_s2, z1_s2, z0_s3, z1_s3;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3, fx_s4, fy_s4, fz_s4;
	logic [FRAC_BITS-1:0] fx_s5, fy_s5, fz_s5, fy_s6, fz_s6, fy_s7, fz_s7;
	logic [FRAC_BITS-1:0] fz_s8, fz_s9;
	logic oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7, oor_s8, oor_s9, oor_s10, oor_s11;
	logic [ADDR_W-1:0] tx0_s3, tx1_s3, ty0_s3, ty1_s3;
	logic [ADDR_W-1:0] ca_s4 [CORNERS];
	logic [TIME_BITS-1:0] rd_s5 [CORNERS];
	logic [PROD_W-1:0] pa_s6 [4], pb_s6 [4];
	logic [TIME_BITS-1:0] c_s7 [4];
	logic [PROD_W-1:0] pa_s8 [2], pb_s8 [2];
	logic [TIME_BITS-1:0] d_s9 [2];
	logic [PROD_W-1:0] pa_s10, pb_s10;
	logic [TIME_BITS-1:0] t_s11;

	// valid bits, loads leave at the volume stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
		end else begin
			if (adv[1]) v_s1 <= in_valid;
			if (adv[2]) v_s2 <= v_s1;
			if (adv[3]) v_s3 <= v_s2;
			if (adv[4]) v_s4 <= v_s3;
			if (adv[5]) v_s5 <= v_s4 && (q_s4 == REQ_QUERY);
			if (adv[6]) v_s6 <= v_s5;
			if (adv[7]) v_s7 <= v_s6;
			if (adv[8]) v_s8 <= v_s7;
			if (adv[9]) v_s9 <= v_s8;
			if (adv[10]) v_s10 <= v_s9;
			if (adv[11]) v_s11 <= v_s10;
		end
	end

	// stage 1: scale positions by the inverse spacings
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			q_s1 <= req_type;
			addr_s1 <= load_addr;
			lt_s1 <= load_time[TIME_BITS-1:0];
			px_s1 <= SCALE_W'(pos_x) * SCALE_W'(inv_dx_q);
			py_s1 <= SCALE_W'(pos_y) * SCALE_W'(inv_dy_q);
			pz_s1 <= SCALE_W'(pos_z) * SCALE_W'(inv_dz_q);
		end
	end

	// stage 2: cell index, weight and edge clamp per axis
	logic [IDX_INT_W-1:0] ix, iy, iz;
	logic [IDX_INT_W:0] ixp, iyp, izp;
	logic cx, cy, cz;

	always_comb begin
		ix = px_s1[SCALE_W-1:SCALE_W-IDX_INT_W];
		iy = py_s1[SCALE_W-1:SCALE_W-IDX_INT_W];
		iz = pz_s1[SCALE_W-1:SCALE_W-IDX_INT_W];
		ixp = {1'b0, ix} + (IDX_INT_W+1)'(1);
		iyp = {1'b0, iy} + (IDX_INT_W+1)'(1);
		izp = {1'b0, iz} + (IDX_INT_W+1)'(1);
		cx = ixp > (IDX_INT_W+1)'(lx);
		cy = iyp > (IDX_INT_W+1)'(ly);
		cz = izp > (IDX_INT_W+1)'(lz);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			q_s2 <= q_s1;
			addr_s2 <= addr_s1;
			lt_s2 <= lt_s1;
			x0_s2 <= (ix > IDX_INT_W'(lx)) ? lx : IDX_W'(ix);
			y0_s2 <= (iy > IDX_INT_W'(ly)) ? ly : IDX_W'(iy);
			z0_s2 <= (iz > IDX_INT_W'(lz)) ? lz : IDX_W'(iz);
			x1_s2 <= cx ? lx : IDX_W'(ixp);
			y1_s2 <= cy ? ly : IDX_W'(iyp);
			z1_s2 <= cz ? lz : IDX_W'(izp);
			fx_s2 <= px_s1[SCALE_W-IDX_INT_W-1 -: FRAC_BITS];
			fy_s2 <= py_s1[SCALE_W-IDX_INT_W-1 -: FRAC_BITS];
			fz_s2 <= pz_s1[SCALE_W-IDX_INT_W-1 -: FRAC_BITS];
			oor_s2 <= cx || cy || cz;
		end
	end

	// stage 3: row and plane offsets
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			q_s3 <= q_s2;
			addr_s3 <= addr_s2;
			lt_s3 <= lt_s2;
			z0_s3 <= z0_s2;
			z1_s3 <= z1_s2;
			tx0_s3 <= ADDR_W'(x0_s2) * nz;
			tx1_s3 <= ADDR_W'(x1_s2) * nz;
			ty0_s3 <= ADDR_W'(y0_s2) * nxnz_q;
			ty1_s3 <= ADDR_W'(y1_s2) * nxnz_q;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;
			oor_s3 <= oor_s2;
		end
	end

	// stage 4: eight corner addresses, corner k = {y, z, x} select bits
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			q_s4 <= q_s3;
			addr_s4 <= addr_s3;
			lt_s4 <= lt_s3;
			for (int k = 0; k < CORNERS; k++) begin
				ca_s4[k] <= ADDR_W'(k[1] ? z1_s3 : z0_s3) + (k[0] ? tx1_s3 : tx0_s3)
					+ (k[2] ? ty1_s3 : ty0_s3);
			end
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			fz_s4 <= fz_s3;
			oor_s4 <= oor_s3;
		end
	end

	// stage 5: volume copies, a load writes all of them
	logic vol_we;
	assign vol_we = v_s4 && (q_s4 == REQ_LOAD);

	for (genvar g = 0; g < CORNERS; g++) begin : g_vol
		tgs_ram #(
			.WIDTH(TIME_BITS),
			.DEPTH(VOL_DEPTH)
		) u_vol (
			.clk(clk),
			.en(adv[5]),
			.we(vol_we),
			.addr(vol_we ? addr_s4 : ca_s4[g]),
			.wdata(lt_s4),
			.rdata(rd_s5[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;
			oor_s5 <= oor_s4;
		end
	end

	// stage 6: x weights applied
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int j = 0; j < 4; j++) begin
				pa_s6[j] <= PROD_W'(rd_s5[2*j]) * PROD_W'(FRAC_ONE - {1'b0, fx_s5});
				pb_s6[j] <= PROD_W'(rd_s5[2*j+1]) * PROD_W'(fx_s5);
			end
			fy_s6 <= fy_s5;
			fz_s6 <= fz_s5;
			oor_s6 <= oor_s5;
		end
	end

	// stage 7: x sums with rounding
	logic [PROD_W-1:0] sx [4];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			sx[j] = pa_s6[j] + pb_s6[j] + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			for (int j = 0; j < 4; j++) begin
				c_s7[j] <= sx[j][FRAC_BITS +: TIME_BITS];
			end
			fy_s7 <= fy_s6;
			fz_s7 <= fz_s6;
			oor_s7 <= oor_s6;
		end
	end

	// stage 8: y weights applied
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			for (int m = 0; m < 2; m++) begin
				pa_s8[m] <= PROD_W'(c_s7[m]) * PROD_W'(FRAC_ONE - {1'b0, fy_s7});
				pb_s8[m] <= PROD_W'(c_s7[m+2]) * PROD_W'(fy_s7);
			end
			fz_s8 <= fz_s7;
			oor_s8 <= oor_s7;
		end
	end

	// stage 9: y sums with rounding
	logic [PROD_W-1:0] sy [2];
	always_comb begin
		for (int m = 0; m < 2; m++) begin
			sy[m] = pa_s8[m] + pb_s8[m] + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			for (int m = 0; m < 2; m++) begin
				d_s9[m] <= sy[m][FRAC_BITS +: TIME_BITS];
			end
			fz_s9 <= fz_s8;
			oor_s9 <= oor_s8;
		end
	end

	// stage 10: z weights applied
	always_ff @(posedge clk) begin
		if (adv[10]) begin
			pa_s10 <= PROD_W'(d_s9[0]) * PROD_W'(FRAC_ONE - {1'b0, fz_s9});
			pb_s10 <= PROD_W'(d_s9[1]) * PROD_W'(fz_s9);
			oor_s10 <= oor_s9;
		end
	end

	// stage 11: final sum into the output register
	logic [PROD_W-1:0] sz;
	assign sz = pa_s10 + pb_s10 + HALF;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			t_s11 <= sz[FRAC_BITS +: TIME_BITS];
			oor_s11 <= oor_s10;
		end
	end

	assign out_valid = v_s11;
	assign time_out = OUT_W'(t_s11);
	assign out_of_range = oor_s11;

endmodule

// File: rtl/tgs_checker.sv
// port-level checks for the trilinear grid sampler, bound to the top level
module tgs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tgs_pkg::OUT_W-1:0]       time_out,
	input logic                            out_of_range
);

	// request side only backs up behind a held result
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request side stalled without a held result");

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(time_out) && $stable(out_of_range))
		else $error("held result changed");

	// a fresh result follows a cycle where the whole pipeline was free to move
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared after a stalled cycle");

	// a stalled request side leaves a result in place next cycle
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("result lost while stalled");

endmodule

bind trilinear_grid_sampler tgs_checker u_tgs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.time_out(time_out),
	.out_of_range(out_of_range)
);

// File: tb/trilinear_grid_sampler_test.sv
// testbench for the trilinear grid sampler: directed and random requests checked against a shadow volume
`timescale 1ns / 100ps

module trilinear_grid_sampler_test;
	import tgs_pkg::*;

	typedef struct {
		logic [OUT_W-1:0] t;
		logic             oor;
	} sample_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  req_type;
	logic [ADDR_W-1:0]     load_addr;
	logic [LOAD_W-1:0]     load_time;
	logic [POS_W-1:0]      pos_x;
	logic [POS_W-1:0]      pos_y;
	logic [POS_W-1:0]      pos_z;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_W-1:0]      time_out;
	logic                  out_of_range;

	// shadow copy of the volume and the registers
	logic [31:0]          vol_shadow [VOL_DEPTH];
	bit                   vol_written [VOL_DEPTH];
	logic [DIM_REG_W-1:0] dim_reg [3];
	logic [INV_W-1:0]     inv_reg [3];

	sample_t expected_q [$];
	int      errors;
	int      sent;
	bit      gaps_on;
	bit      stalls_on;
	int      hold_left;

	trilinear_grid_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .load_addr(load_addr), .load_time(load_time),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.time_out(time_out), .out_of_range(out_of_range)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// effective size of an axis
	function automatic int unsigned used_dim(input logic [DIM_REG_W-1:0] d);
		if (d == 0) return 1;
		if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
		return 32'(d);
	endfunction

	// index pair, weight and clamp flag for one axis
	function automatic void scale_axis(input logic [POS_W-1:0] pos, input logic [INV_W-1:0] inv,
			input int unsigned dim, output int unsigned lo, output int unsigned hi,
			output logic [15:0] w, inout bit clamp);
		logic [47:0] p;
		p = {24'b0, pos} * {24'b0, inv};
		lo = 32'(p[47:32]);
		hi = lo + 1;
		w = p[31:16];
		if (lo > dim - 1) begin
			lo = dim - 1;
			clamp = 1;
		end
		if (hi > dim - 1) begin
			hi = dim - 1;
			clamp = 1;
		end
	endfunction

	// corner addresses, slot = z*4 + y*2 + x
	function automatic void locate_corners(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, output logic [ADDR_W-1:0] addr [8],
			output logic [15:0] wx, output logic [15:0] wy, output logic [15:0] wz, output bit clamp);
		int unsigned nz, nx, ny;
		int unsigned xi [2], yi [2], zi [2];
		nz = used_dim(dim_reg[CFG_DIM_Z]);
		nx = used_dim(dim_reg[CFG_DIM_X]);
		ny = used_dim(dim_reg[CFG_DIM_Y]);
		clamp = 0;
		scale_axis(px, inv_reg[0], nx, xi[0], xi[1], wx, clamp);
		scale_axis(py, inv_reg[1], ny, yi[0], yi[1], wy, clamp);
		scale_axis(pz, inv_reg[2], nz, zi[0], zi[1], wz, clamp);
		for (int k = 0; k < 8; k++)
			addr[k] = ADDR_W'(zi[k/4] + xi[k%2] * nz + yi[(k/2)%2] * nx * nz);
	endfunction

	// one linear step, rounding half up
	function automatic logic [63:0] blend(input logic [63:0] a, input logic [63:0] b,
			input logic [15:0] f);
		return (a * (64'd65536 - f) + b * f + 64'd32768) >> 16;
	endfunction

	function automatic sample_t interpolate(input logic [POS_W-1:0] px,
			input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz);
		logic [ADDR_W-1:0] a [8];
		logic [15:0] wx, wy, wz;
		bit clamp;
		logic [63:0] c00, c01, c10, c11, c0, c1;
		sample_t r;
		locate_corners(px, py, pz, a, wx, wy, wz, clamp);
		c00 = blend(64'(vol_shadow[a[0]]), 64'(vol_shadow[a[1]]), wx);
		c01 = blend(64'(vol_shadow[a[4]]), 64'(vol_shadow[a[5]]), wx);
		c10 = blend(64'(vol_shadow[a[2]]), 64'(vol_shadow[a[3]]), wx);
		c11 = blend(64'(vol_shadow[a[6]]), 64'(vol_shadow[a[7]]), wx);
		c0 = blend(c00, c10, wy);
		c1 = blend(c01, c11, wy);
		r.t = OUT_W'(blend(c0, c1, wz));
		r.oor = clamp;
		return r;
	endfunction

	// position aimed at a chosen cell of the current grid, sometimes fully random
	function automatic logic [POS_W-1:0] aim_pos(input logic [INV_W-1:0] inv,
			input logic [DIM_REG_W-1:0] d);
		logic [63:0] p;
		if (inv == 0 || $urandom_range(7) == 0) return POS_W'($urandom);
		p = ({32'b0, 32'($urandom_range(used_dim(d), 0))} << 32) | {32'b0, 32'($urandom)};
		p = p / {40'b0, inv};
		if (p > 64'hFFFFFF) p = 64'hFFFFFF;
		return p[POS_W-1:0];
	endfunction

	// one request through the handshake, shadow updated on acceptance
	task automatic send_req(input logic kind, input logic [ADDR_W-1:0] a, input logic [31:0] v,
			input logic [POS_W-1:0] px, input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz);
		if (gaps_on) begin
			while ($urandom_range(99) < 22) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= kind;
		load_addr <= a;
		load_time <= v;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (kind == REQ_LOAD) begin
			vol_shadow[a] = v;
			vol_written[a] = 1;
		end else begin
			expected_q.push_back(interpolate(px, py, pz));
		end
	endtask

	task automatic load_sample(input logic [ADDR_W-1:0] a);
		send_req(REQ_LOAD, a, $urandom, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
	endtask

	// query, loading any corner never written first
	task automatic query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz);
		logic [ADDR_W-1:0] a [8];
		logic [15:0] wx, wy, wz;
		bit clamp;
		locate_corners(px, py, pz, a, wx, wy, wz, clamp);
		for (int k = 0; k < 8; k++)
			if (!vol_written[a[k]]) load_sample(a[k]);
		send_req(REQ_QUERY, ADDR_W'($urandom), $urandom, px, py, pz);
	endtask

	task automatic release_bus();
		in_valid <= 1'b0;
	endtask

	// wait for every result, then for loads still in the pipe
	task automatic drain();
		release_bus();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIM_Z:  dim_reg[CFG_DIM_Z] = val[DIM_REG_W-1:0];
			CFG_DIM_X:  dim_reg[CFG_DIM_X] = val[DIM_REG_W-1:0];
			CFG_DIM_Y:  dim_reg[CFG_DIM_Y] = val[DIM_REG_W-1:0];
			CFG_INV_DX: inv_reg[0] = val;
			CFG_INV_DY: inv_reg[1] = val;
			CFG_INV_DZ: inv_reg[2] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_grid(input logic [DIM_REG_W-1:0] nz, input logic [DIM_REG_W-1:0] nx,
			input logic [DIM_REG_W-1:0] ny, input logic [INV_W-1:0] ix,
			input logic [INV_W-1:0] iy, input logic [INV_W-1:0] iz);
		drain();
		write_reg(CFG_DIM_Z, CFG_DATA_W'(nz));
		write_reg(CFG_DIM_X, CFG_DATA_W'(nx));
		write_reg(CFG_DIM_Y, CFG_DATA_W'(ny));
		write_reg(CFG_INV_DX, ix);
		write_reg(CFG_INV_DY, iy);
		write_reg(CFG_INV_DZ, iz);
	endtask

	task automatic random_query();
		query(aim_pos(inv_reg[0], dim_reg[CFG_DIM_X]), aim_pos(inv_reg[1], dim_reg[CFG_DIM_Y]),
			aim_pos(inv_reg[2], dim_reg[CFG_DIM_Z]));
	endtask

	// reset values, origin, far corner and a wide load
	task automatic test_reset_grid();
		query('0, '0, '0);
		query(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		query(24'h000A80, 24'h001F40, 24'h000123);
		send_req(REQ_LOAD, 15'h7FFF, 32'hFFFFFFFF, '0, '0, '0);
		send_req(REQ_LOAD, 15'h0000, 32'h00000000, '0, '0, '0);
		query('0, '0, '0);
		query(24'h00013F, 24'h0001FF, 24'h0000FF);
	endtask

	// dimensions of zero and above the maximum, zero and full inverse spacing
	task automatic test_special_grids();
		set_grid(6'd0, 6'd63, 6'd33, 24'h000000, 24'hFFFFFF, 24'h800000);
		query(24'h123456, 24'h000101, 24'h000200);
		query(24'hFFFFFF, 24'h001FFF, 24'h000000);
		set_grid(6'd1, 6'd1, 6'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		query('0, '0, '0);
		query(24'h000080, 24'h000080, 24'h000080);
		// exactly on the last sample of the x axis, inverse spacing of one half
		set_grid(6'd4, 6'd5, 6'd6, 24'h800000, 24'h800000, 24'h800000);
		query(24'h000800, 24'h000600, 24'h000400);
		query(24'h0007FF, 24'h0005FF, 24'h0003FF);
		query(24'h000100, 24'h000300, 24'h000180);
	endtask

	// random grids, most queries aimed inside them, at least 80 requests per grid
	task automatic test_random_grids();
		for (int phase = 0; phase < 10; phase++) begin
			int start;
			set_grid(DIM_REG_W'($urandom_range(63)), DIM_REG_W'($urandom_range(12, 1)),
				DIM_REG_W'($urandom_range(12, 1)), INV_W'($urandom),
				INV_W'($urandom_range(24'hFFFFFF, 24'h100000)), INV_W'($urandom));
			gaps_on = (phase != 4);
			stalls_on = (phase != 4);
			start = sent;
			while (sent - start < 80) begin
				if ($urandom_range(4) == 0) load_sample(ADDR_W'($urandom));
				else random_query();
			end
		end
		gaps_on = 1;
		stalls_on = 1;
	endtask

	// receiver holds off until the pipe backs up, the sender waits for every result, then sends more
	task automatic test_backpressure();
		set_grid(6'd4, 6'd4, 6'd4, 24'h400000, 24'h400000, 24'h400000);
		hold_left = 300;
		for (int n = 0; n < 30; n++) random_query();
		drain();
		for (int n = 0; n < 20; n++) random_query();
	endtask

	// result check against the oldest expectation and receiver stalls
	always @(posedge clk) begin
		sample_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result t=%h oor=%b", time_out, out_of_range);
			end else begin
				e = expected_q.pop_front();
				if (time_out !== e.t || out_of_range !== e.oor) begin
					errors++;
					if (errors <= 10)
						$display("result mismatch: expected t=%h oor=%b, got t=%h oor=%b",
							e.t, e.oor, time_out, out_of_range);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !stalls_on || $urandom_range(99) >= 22;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		load_addr = '0;
		load_time = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		out_ready = 1'b0;
		errors = 0;
		sent = 0;
		gaps_on = 1;
		stalls_on = 1;
		hold_left = 0;
		for (int k = 0; k < 3; k++) begin
			dim_reg[k] = DIM_RST;
			inv_reg[k] = INV_RST;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_grid();
		test_special_grids();
		test_random_grids();
		test_backpressure();
		drain();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/tgs_pkg.sv
rtl/tgs_ram.sv
rtl/trilinear_grid_sampler.sv
rtl/tgs_checker.sv
tb/trilinear_grid_sampler_test.sv
